/* hw/rtl/krq_pkg.sv */
package krq_pkg;

	localparam int DEF_TRACK_COUNT     = 8;
	localparam int DEF_SLOTS_PER_TRACK = 8;
	localparam int DEF_PRIORITY_BITS   = 16;

	// Width of positions and counts handed to the cells; holds values up to 511.
	localparam int CNT_W = 9;

	localparam logic [3:0] M_ENQUEUE   = 4'd0;
	localparam logic [3:0] M_APPEND    = 4'd1;
	localparam logic [3:0] M_POP_NEXT  = 4'd2;
	localparam logic [3:0] M_POP_FOCUS = 4'd3;
	localparam logic [3:0] M_MARK_ATT  = 4'd4;
	localparam logic [3:0] M_SET_COMM  = 4'd5;
	localparam logic [3:0] M_CLR_QUEUE = 4'd6;
	localparam logic [3:0] M_CLR_ATT   = 4'd7;
	localparam logic [3:0] M_QUERY     = 4'd8;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_WRITE,
		OP_SETPRIO,
		OP_SHIFT,
		OP_SORT
	} cell_op_t;

	typedef struct packed {
		logic [2:0]  track;
		logic [2:0]  slot;
		logic [15:0] prio;
	} entry_t;

	typedef struct packed {
		cell_op_t         op;
		logic [CNT_W-1:0] pos;
		logic             phase;
		entry_t           fresh;
	} cell_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [2:0]       track;
		logic [2:0]       slot;
	} cell_look_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [2:0]  track;
		logic [2:0]  slot;
		logic [15:0] priority_req;
		logic        has_payload;
		logic        needs_load;
		logic        flag_value;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  out_track;
		logic [2:0]  out_slot;
		logic [15:0] out_priority;
		logic [6:0]  queue_count;
		logic        is_queued;
		logic        focus_pending;
	} res_t;

endpackage

/* hw/rtl/keyed_priority_restore_queue.sv */
// Keyed restore queue: a list of (track, slot, priority) entries held in a row of
// cells, lowest priority value at the head, equal priorities in arrival order.
// An operation is issued by raising start with req filled in while busy is low; it
// is taken at that clock edge and busy rises on the next cycle. When the operation
// finishes, result is shown for exactly one cycle with strobe high, and busy falls
// in that same cycle, so the next item may be issued while the result is shown.
// The receiver cannot hold results off.
// An append puts its entry at the tail without sorting. An enqueue runs one
// odd-even sort phase per queued entry after it writes or updates its entry. A
// pop-next shifts the row once for every head entry it drops and once more for
// the entry it returns. The cells exchange data only with their neighbors: one
// sort phase or one shift of the whole row per cycle.
// Reset clears the entry count and the attempted and committed maps; the cell
// contents need no reset, since only cells below the count are ever looked at.
module keyed_priority_restore_queue #(
	parameter int TRACK_COUNT     = krq_pkg::DEF_TRACK_COUNT,
	parameter int SLOTS_PER_TRACK = krq_pkg::DEF_SLOTS_PER_TRACK,
	parameter int PRIORITY_BITS   = krq_pkg::DEF_PRIORITY_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  krq_pkg::req_t req,
	output logic          strobe,
	output krq_pkg::res_t result
);
	import krq_pkg::*;

	localparam int KC = TRACK_COUNT * SLOTS_PER_TRACK;
	localparam int IW = (KC > 1) ? $clog2(KC) : 1;
	localparam int CW = $clog2(KC + 1);
	localparam logic [15:0] PMASK = 16'hFFFF >> (16 - PRIORITY_BITS);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SORT, S_POP} state_t;

	state_t        state_q, state_d;
	req_t          req_q;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] ph_q, ph_d;
	logic [KC-1:0] att_q, com_q;
	res_t          res_q, res_d;
	logic          strobe_q, fin;

	cell_cmd_t  cmd;
	cell_look_t look;
	entry_t     cell_e [KC];
	logic [KC-1:0] match;

	logic          key_ok, found, seen;
	logic [CW-1:0] first_pos;
	entry_t        hit_e;
	logic [IW-1:0] req_idx, hit_idx, head_idx;
	logic          hit_done, head_done;

	// The row of cells. Cell i sees its two neighbors; the ends see zeros.
	for (genvar i = 0; i < KC; i++) begin : g_cell
		entry_t l_e, r_e;
		if (i == 0) begin : g_l0
			assign l_e = '0;
		end else begin : g_l
			assign l_e = cell_e[i-1];
		end
		if (i == KC - 1) begin : g_rn
			assign r_e = '0;
		end else begin : g_r
			assign r_e = cell_e[i+1];
		end
		krq_cell #(.IDX(i)) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.look  (look),
			.left  (l_e),
			.right (r_e),
			.entry (cell_e[i]),
			.match (match[i])
		);
	end

	assign look.count = CNT_W'(count_q);
	assign look.track = req_q.track;
	assign look.slot  = req_q.slot;

	assign key_ok = ({2'b00, req_q.track} < 5'(TRACK_COUNT)) &&
	                ({2'b00, req_q.slot} < 5'(SLOTS_PER_TRACK));

	// First matching cell: its position and its entry.
	always_comb begin
		seen      = 1'b0;
		first_pos = '0;
		hit_e     = '0;
		for (int i = 0; i < KC; i++) begin
			if (match[i] && !seen) begin
				first_pos = CW'(i);
				hit_e     = cell_e[i];
			end
			seen = seen | match[i];
		end
		found = seen;
	end

	// Key index into the flag maps is track * SLOTS_PER_TRACK + slot.
	always_comb begin
		logic [7:0] r_full, h_full, d_full;
		r_full   = 8'(req_q.track) * 8'(SLOTS_PER_TRACK) + 8'(req_q.slot);
		h_full   = 8'(hit_e.track) * 8'(SLOTS_PER_TRACK) + 8'(hit_e.slot);
		d_full   = 8'(cell_e[0].track) * 8'(SLOTS_PER_TRACK) + 8'(cell_e[0].slot);
		req_idx  = r_full[IW-1:0];
		hit_idx  = h_full[IW-1:0];
		head_idx = d_full[IW-1:0];
	end

	assign hit_done  = att_q[hit_idx] | com_q[hit_idx];
	assign head_done = att_q[head_idx] | com_q[head_idx];

	// Sequencing of one operation and the commands broadcast to the cells.
	always_comb begin
		cmd.op          = OP_HOLD;
		cmd.pos         = CNT_W'(first_pos);
		cmd.phase       = ph_q[0];
		cmd.fresh.track = req_q.track;
		cmd.fresh.slot  = req_q.slot;
		cmd.fresh.prio  = req_q.priority_req & PMASK;
		state_d         = state_q;
		count_d         = count_q;
		ph_d            = ph_q;
		fin             = 1'b0;
		res_d           = '0;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (req_q.mode)
					M_ENQUEUE: begin
						fin = 1'b1;
						if (key_ok && req_q.has_payload) begin
							if (found) begin
								cmd.op  = OP_SETPRIO;
								fin     = 1'b0;
							end else if (req_q.needs_load && (count_q < CW'(KC))) begin
								cmd.op  = OP_WRITE;
								cmd.pos = CNT_W'(count_q);
								count_d = count_q + CW'(1);
								fin     = 1'b0;
							end
						end
						if (!fin) begin
							state_d = S_SORT;
							ph_d    = '0;
						end
					end
					M_APPEND: begin
						fin = 1'b1;
						if (key_ok && (count_q < CW'(KC))) begin
							cmd.op   = OP_WRITE;
							cmd.pos  = CNT_W'(count_q);
							count_d  = count_q + CW'(1);
							res_d.ok = 1'b1;
						end
					end
					M_POP_NEXT: begin
						state_d = S_POP;
					end
					M_POP_FOCUS: begin
						fin = 1'b1;
						if (key_ok && found) begin
							cmd.op  = OP_SHIFT;
							count_d = count_q - CW'(1);
							if (!hit_done) begin
								res_d.ok           = 1'b1;
								res_d.out_track    = hit_e.track;
								res_d.out_slot     = hit_e.slot;
								res_d.out_priority = hit_e.prio;
							end
						end
					end
					M_MARK_ATT, M_SET_COMM: begin
						fin      = 1'b1;
						res_d.ok = key_ok;
					end
					M_CLR_QUEUE: begin
						fin      = 1'b1;
						count_d  = '0;
						res_d.ok = 1'b1;
					end
					M_CLR_ATT: begin
						fin      = 1'b1;
						res_d.ok = 1'b1;
					end
					M_QUERY: begin
						fin                 = 1'b1;
						res_d.ok            = 1'b1;
						res_d.is_queued     = key_ok && found;
						res_d.focus_pending = key_ok && found && !hit_done;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_SORT: begin
				// One phase per queued entry leaves the row fully sorted.
				cmd.op = OP_SORT;
				ph_d   = ph_q + CW'(1);
				if ((ph_q + CW'(1)) >= count_q) begin
					fin      = 1'b1;
					res_d.ok = 1'b1;
				end
			end
			S_POP: begin
				if (count_q == '0) begin
					fin = 1'b1;
				end else begin
					cmd.op  = OP_SHIFT;
					cmd.pos = '0;
					count_d = count_q - CW'(1);
					if (!head_done) begin
						fin                = 1'b1;
						res_d.ok           = 1'b1;
						res_d.out_track    = cell_e[0].track;
						res_d.out_slot     = cell_e[0].slot;
						res_d.out_priority = cell_e[0].prio;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) state_d = S_IDLE;
		res_d.queue_count = 7'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ph_q     <= '0;
			att_q    <= '0;
			com_q    <= '0;
			strobe_q <= 1'b0;
			res_q    <= '0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			ph_q     <= ph_d;
			strobe_q <= fin;
			if (fin) res_q <= res_d;
			if (state_q == S_EXEC) begin
				if (req_q.mode == M_MARK_ATT && key_ok) att_q[req_idx] <= 1'b1;
				if (req_q.mode == M_SET_COMM && key_ok) com_q[req_idx] <= req_q.flag_value;
				if (req_q.mode == M_CLR_ATT) att_q <= '0;
			end
		end
	end

	// Request register.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) req_q <= req;
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = res_q;

endmodule

/* hw/rtl/krq_cell.sv */
module krq_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  krq_pkg::cell_cmd_t  cmd,
	input  krq_pkg::cell_look_t look,
	input  krq_pkg::entry_t     left,
	input  krq_pkg::entry_t     right,
	output krq_pkg::entry_t     entry,
	output logic                match
);
	import krq_pkg::*;

	localparam logic [CNT_W-1:0] ME = CNT_W'(IDX);

	entry_t e_q;
	logic   occ;
	logic   swap;

	// In a sort phase the cell pairs with its right neighbor when its index parity
	// equals the phase, else with its left one. Swapping only on strictly greater
	// keeps equal priorities in their order.
	always_comb begin
		occ = ME < look.count;
		if (ME[0] == cmd.phase) begin
			swap = ((ME + CNT_W'(1)) < look.count) && (e_q.prio > right.prio);
		end else begin
			swap = (IDX > 0) && occ && (left.prio > e_q.prio);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_WRITE: begin
				if (ME == cmd.pos) e_q <= cmd.fresh;
			end
			OP_SETPRIO: begin
				if (ME == cmd.pos) e_q.prio <= cmd.fresh.prio;
			end
			OP_SHIFT: begin
				if (ME >= cmd.pos) e_q <= right;
			end
			OP_SORT: begin
				if (swap) e_q <= (ME[0] == cmd.phase) ? right : left;
			end
			default: begin
			end
		endcase
	end

	assign entry = e_q;
	assign match = occ && (e_q.track == look.track) && (e_q.slot == look.slot);

endmodule
